// ===== rtl/rrt_pkg.sv =====
// rrt_pkg: shared constants, status codes and types for the tree extend unit
// no dependencies
package rrt_pkg;

  localparam int MAX_NODES  = 512;
  localparam int COORD_BITS = 10;
  localparam int IDX_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int STEP_BITS  = 11;
  localparam int DSQ_BITS   = 2 * COORD_BITS + 1;
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = STEP_BITS + COORD_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_PLANT = 3'd1;
  localparam logic [2:0] ST_DUP   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [CFG_IDX_BITS-1:0] REG_STEP     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROOT_COL = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROOT_ROW = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_COL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_ROW = 3'd4;

  localparam int NODE_BITS = 2 * COORD_BITS + IDX_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [IDX_BITS-1:0]   parent;
  } node_t;

endpackage

// ===== rtl/rrt_tree_extend_unit.sv =====
// rrt_tree_extend_unit: top level, node store, nearest search, step and duplicate check
// depends on rrt_pkg, rrt_ram, rrt_divsqrt
//
// A plant request writes the root and goes straight to the result. An extend request
// runs a nearest search over the node memory: for each node a read, the squared
// distance and an 11 step bit serial square root; then two divisions when the step
// is shortened, and a second memory pass for the duplicate check. Busy is high
// from acceptance until the result strobe; the done strobe is high for one cycle
// and cannot be held off.
module rrt_tree_extend_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation,
  input  logic [rrt_pkg::COORD_BITS-1:0]     sample_col,
  input  logic [rrt_pkg::COORD_BITS-1:0]     sample_row,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rrt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                               done,
  output logic [2:0]                         status,
  output logic [rrt_pkg::COORD_BITS-1:0]     new_col,
  output logic [rrt_pkg::COORD_BITS-1:0]     new_row,
  output logic [rrt_pkg::IDX_BITS-1:0]       parent_index,
  output logic [rrt_pkg::IDX_BITS-1:0]       node_index,
  output logic                               reached_goal
);
  import rrt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_DIST  = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_DIVC  = 10'b0000010000,
    S_DIVR  = 10'b0000100000,
    S_DUPRD = 10'b0001000000,
    S_DUP   = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  logic [STEP_BITS-1:0]  max_step;
  logic [COORD_BITS-1:0] root_col, root_row, goal_col, goal_row;
  logic [CNT_BITS-1:0]   node_count;
  logic [COORD_BITS-1:0] sc, sr, nc, nr, near_col, near_row;
  logic [CNT_BITS-1:0]   idx;
  logic [IDX_BITS-1:0]   best, cur;
  logic [DIST_BITS-1:0]  bestd;
  logic                  have_best;

  // node memory
  logic                  ram_we;
  logic [IDX_BITS-1:0]   ram_addr;
  node_t                 ram_wdata, ram_rdata;

  rrt_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_nodes (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // square root and divider
  logic                  sqrt_go, div_go, ds_done, ds_rem_nz;
  logic [DSQ_BITS-1:0]   radicand;
  logic [PROD_BITS-1:0]  dividend, ds_result;
  logic [COORD_BITS:0]   dcol, drow;
  logic [COORD_BITS-1:0] adc, adr;
  logic [DSQ_BITS-1:0]   dsq;
  logic                  neg_col, neg_row;

  rrt_divsqrt u_ds (
    .clk(clk), .rst(rst), .sqrt_go(sqrt_go), .radicand(radicand),
    .div_go(div_go), .dividend(dividend), .divisor(bestd),
    .done(ds_done), .result(ds_result), .rem_nz(ds_rem_nz)
  );

  // differences against the node read from memory or the nearest node
  assign dcol = {1'b0, sc} - {1'b0, (state == S_DIST) ? ram_rdata.col : near_col};
  assign drow = {1'b0, sr} - {1'b0, (state == S_DIST) ? ram_rdata.row : near_row};
  assign adc = dcol[COORD_BITS] ? COORD_BITS'(-dcol) : dcol[COORD_BITS-1:0];
  assign adr = drow[COORD_BITS] ? COORD_BITS'(-drow) : drow[COORD_BITS-1:0];

  // squared distance register feeds the sqrt unit
  always_ff @(posedge clk) begin
    dsq <= DSQ_BITS'(adc * adc) + DSQ_BITS'(adr * adr);
  end
  assign radicand = dsq;

  // step offset: registered product, then divide
  logic [PROD_BITS-1:0] prod;
  logic                 div_pending;
  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(max_step * ((state == S_DIVR) ? adr : adc));
  end
  assign dividend = prod;

  logic [COORD_BITS-1:0] step_sum;
  logic [COORD_BITS-1:0] near_sel;
  logic                  neg_sel;
  logic [COORD_BITS-1:0] qoff;
  assign near_sel = (state == S_DIVC) ? near_col : near_row;
  assign neg_sel  = (state == S_DIVC) ? neg_col : neg_row;
  assign qoff = ds_result[COORD_BITS-1:0] + COORD_BITS'(ds_rem_nz);
  assign step_sum = neg_sel ? near_sel - qoff : near_sel + ds_result[COORD_BITS-1:0];

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // memory port control
  always_comb begin
    ram_we = (state == S_WRITE) || (state == S_IDLE && start && !operation);
    ram_wdata.col = (state == S_WRITE) ? nc : root_col;
    ram_wdata.row = (state == S_WRITE) ? nr : root_row;
    ram_wdata.parent = (state == S_WRITE) ? best : '0;
    ram_addr = (state == S_WRITE) ? node_count[IDX_BITS-1:0] :
               (state == S_IDLE) ? '0 : idx[IDX_BITS-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= STEP_BITS'(50);
      root_col <= COORD_BITS'(49); root_row <= COORD_BITS'(49);
      goal_col <= COORD_BITS'(99); goal_row <= COORD_BITS'(99);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP:     max_step <= cfg_data;
        REG_ROOT_COL: root_col <= cfg_data[COORD_BITS-1:0];
        REG_ROOT_ROW: root_row <= cfg_data[COORD_BITS-1:0];
        REG_GOAL_COL: goal_col <= cfg_data[COORD_BITS-1:0];
        REG_GOAL_ROW: goal_row <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= '0;
      done <= 1'b0;
      sqrt_go <= 1'b0;
      div_go <= 1'b0;
      div_pending <= 1'b0;
    end else begin
      done <= 1'b0;
      sqrt_go <= 1'b0;
      div_go <= 1'b0;
      div_pending <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            sc <= sample_col; sr <= sample_row;
            status <= ST_ADDED; new_col <= '0; new_row <= '0;
            parent_index <= '0; node_index <= '0; reached_goal <= 1'b0;
            idx <= '0; have_best <= 1'b0; best <= '0;
            if (!operation) begin
              node_count <= CNT_BITS'(1);
              status <= ST_PLANT; new_col <= root_col; new_row <= root_row;
              state <= S_OUT;
            end else if (node_count == '0) begin
              status <= ST_EMPTY; state <= S_OUT;
            end else if (node_count == CNT_BITS'(MAX_NODES)) begin
              status <= ST_FULL; state <= S_OUT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_DIST;
        S_DIST: begin
          cur <= idx[IDX_BITS-1:0];
          near_col <= ram_rdata.col; near_row <= ram_rdata.row;
          sqrt_go <= 1'b1;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (ds_done) begin
            if (!have_best || DIST_BITS'(ds_result) < bestd) begin
              bestd <= DIST_BITS'(ds_result);
              best <= cur;
              have_best <= 1'b1;
              nc <= near_col; nr <= near_row;
            end
            if (idx + 1'b1 < node_count) begin
              idx <= idx + 1'b1;
              state <= S_RD;
            end else begin
              near_col <= (!have_best || DIST_BITS'(ds_result) < bestd) ? near_col : nc;
              near_row <= (!have_best || DIST_BITS'(ds_result) < bestd) ? near_row : nr;
              div_pending <= 1'b1;
              state <= S_DIVC;
            end
          end
        end
        S_DIVC: begin
          // product registers from near_col this cycle, divide the next
          if (div_pending) begin
            neg_col <= dcol[COORD_BITS];
            neg_row <= drow[COORD_BITS];
            if (bestd <= DIST_BITS'(max_step)) begin
              nc <= sc; nr <= sr; idx <= '0; state <= S_DUPRD;
            end else begin
              div_go <= 1'b1;
            end
          end else if (ds_done) begin
            nc <= step_sum;
            div_pending <= 1'b1;
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_pending) begin
            div_go <= 1'b1;
          end else if (ds_done) begin
            nr <= step_sum;
            idx <= '0;
            state <= S_DUPRD;
          end
        end
        S_DUPRD: state <= S_DUP;
        S_DUP: begin
          if (ram_rdata.col == nc && ram_rdata.row == nr) begin
            status <= ST_DUP; state <= S_OUT;
          end else if (idx + 1'b1 < node_count) begin
            idx <= idx + 1'b1; state <= S_DUPRD;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          node_count <= node_count + 1'b1;
          new_col <= nc; new_row <= nr;
          parent_index <= best;
          node_index <= node_count[IDX_BITS-1:0];
          reached_goal <= (nc == goal_col) && (nr == goal_row);
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rrt_ram.sv =====
// rrt_ram: generic single port synchronous ram, registered read
// no dependencies
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read first port with registered read
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/rrt_divsqrt.sv =====
// rrt_divsqrt: iterative integer square root and unsigned divider, one bit a cycle
// depends on rrt_pkg
module rrt_divsqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sqrt_go,
  input  logic [rrt_pkg::DSQ_BITS-1:0]  radicand,
  input  logic                          div_go,
  input  logic [rrt_pkg::PROD_BITS-1:0] dividend,
  input  logic [rrt_pkg::DIST_BITS-1:0] divisor,
  output logic                          done,
  output logic [rrt_pkg::PROD_BITS-1:0] result,
  output logic                          rem_nz
);
  import rrt_pkg::*;

  localparam int SQ_STEPS = (DSQ_BITS + 1) / 2;
  localparam int CBITS = $clog2(PROD_BITS + 1);

  logic                  busy, is_sqrt;
  logic [CBITS-1:0]      cnt;
  logic [PROD_BITS-1:0]  q;
  logic [PROD_BITS:0]    rem;
  logic [PROD_BITS-1:0]  num;
  logic [DIST_BITS-1:0]  den;
  logic [2*SQ_STEPS-1:0] rad;
  logic [SQ_STEPS+1:0]   srem;
  logic [SQ_STEPS+1:0]   strial;
  logic [PROD_BITS:0]    dshift;

  assign dshift = {rem[PROD_BITS-1:0], num[PROD_BITS-1]};
  assign strial = {srem[SQ_STEPS-1:0], rad[2*SQ_STEPS-1 -: 2]}
                  - {q[SQ_STEPS-1:0], 2'b01};
  assign result = q;
  assign rem_nz = (rem != '0);

  // restoring sqrt and division sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (sqrt_go) begin
        busy <= 1'b1; is_sqrt <= 1'b1;
        cnt <= CBITS'(SQ_STEPS);
        rad <= (2*SQ_STEPS)'(radicand);
        srem <= '0; q <= '0;
      end else if (div_go) begin
        busy <= 1'b1; is_sqrt <= 1'b0;
        cnt <= CBITS'(PROD_BITS);
        num <= dividend; den <= divisor;
        rem <= '0; q <= '0;
      end else if (busy) begin
        if (is_sqrt) begin
          rad <= rad << 2;
          if (!strial[SQ_STEPS+1]) begin
            srem <= strial;
            q <= {q[PROD_BITS-2:0], 1'b1};
          end else begin
            srem <= {srem[SQ_STEPS-1:0], rad[2*SQ_STEPS-1 -: 2]};
            q <= {q[PROD_BITS-2:0], 1'b0};
          end
        end else begin
          num <= num << 1;
          if (dshift >= (PROD_BITS+1)'(den)) begin
            rem <= dshift - (PROD_BITS+1)'(den);
            q <= {q[PROD_BITS-2:0], 1'b1};
          end else begin
            rem <= dshift;
            q <= {q[PROD_BITS-2:0], 1'b0};
          end
        end
        cnt <= cnt - 1'b1;
        if (cnt == CBITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== test/rrt_tree_extend_checker.sv =====
// rrt_tree_extend_checker: watches the request, config and result channels of the
// tree extend unit, predicts each result and compares; depends on rrt_pkg
`timescale 1ns / 100ps

module rrt_tree_extend_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               operation,
  input  logic [rrt_pkg::COORD_BITS-1:0]     sample_col,
  input  logic [rrt_pkg::COORD_BITS-1:0]     sample_row,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [rrt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rrt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               done,
  input  logic [2:0]                         status,
  input  logic [rrt_pkg::COORD_BITS-1:0]     new_col,
  input  logic [rrt_pkg::COORD_BITS-1:0]     new_row,
  input  logic [rrt_pkg::IDX_BITS-1:0]       parent_index,
  input  logic [rrt_pkg::IDX_BITS-1:0]       node_index,
  input  logic                               reached_goal,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 node_total,
  output logic [rrt_pkg::COORD_BITS-1:0]     last_col,
  output logic [rrt_pkg::COORD_BITS-1:0]     last_row
);
  import rrt_pkg::*;

  typedef struct packed {
    logic [2:0]            st;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [IDX_BITS-1:0]   parent;
    logic [IDX_BITS-1:0]   idx;
    logic                  goal;
  } outcome_t;

  outcome_t outcome_q[$];

  // predictor copy of the tree and registers
  logic [COORD_BITS-1:0] tree_col [MAX_NODES];
  logic [COORD_BITS-1:0] tree_row [MAX_NODES];
  int                    tree_size;
  logic [STEP_BITS-1:0]  step_len;
  logic [COORD_BITS-1:0] root_c, root_r, goal_c, goal_r;

  // digit by digit integer square root
  function automatic longint isqrt(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 40;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint dist_of(int ac, int ar, int bc, int br);
    longint dc, dr;
    dc = ac - bc;
    dr = ar - br;
    return isqrt(dc * dc + dr * dr);
  endfunction

  // work out the result of one request and update the tree
  function automatic outcome_t grow_tree(logic op, logic [COORD_BITS-1:0] sc,
                                         logic [COORD_BITS-1:0] sr);
    outcome_t o;
    int best;
    longint bd, d;
    logic [COORD_BITS-1:0] nc, nr;
    o = '0;
    if (!op) begin
      tree_col[0] = root_c;
      tree_row[0] = root_r;
      tree_size = 1;
      o.st = ST_PLANT;
      o.col = root_c;
      o.row = root_r;
      return o;
    end
    if (tree_size == 0) begin
      o.st = ST_EMPTY;
      return o;
    end
    if (tree_size >= MAX_NODES) begin
      o.st = ST_FULL;
      return o;
    end
    best = 0;
    bd = dist_of(sc, sr, tree_col[0], tree_row[0]);
    for (int i = 1; i < tree_size; i++) begin
      d = dist_of(sc, sr, tree_col[i], tree_row[i]);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    if (bd > step_len) begin
      nc = COORD_BITS'(longint'(tree_col[best]) +
           floor_quot(longint'(step_len) * (longint'(sc) - tree_col[best]), bd));
      nr = COORD_BITS'(longint'(tree_row[best]) +
           floor_quot(longint'(step_len) * (longint'(sr) - tree_row[best]), bd));
    end else begin
      nc = sc;
      nr = sr;
    end
    for (int i = 0; i < tree_size; i++) begin
      if (tree_col[i] == nc && tree_row[i] == nr) begin
        o.st = ST_DUP;
        return o;
      end
    end
    tree_col[tree_size] = nc;
    tree_row[tree_size] = nr;
    o.st = ST_ADDED;
    o.col = nc;
    o.row = nr;
    o.parent = IDX_BITS'(best);
    o.idx = IDX_BITS'(tree_size);
    o.goal = (nc == goal_c && nr == goal_r);
    tree_size++;
    return o;
  endfunction

  assign pending = outcome_q.size();
  assign node_total = tree_size;

  // watch the channels at each rising edge
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      tree_size = 0;
      step_len <= 11'd50;
      root_c <= 10'd49;
      root_r <= 10'd49;
      goal_c <= 10'd99;
      goal_r <= 10'd99;
      fail_count <= 0;
      last_col <= '0;
      last_row <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP:     step_len <= cfg_data;
          REG_ROOT_COL: root_c <= cfg_data[COORD_BITS-1:0];
          REG_ROOT_ROW: root_r <= cfg_data[COORD_BITS-1:0];
          REG_GOAL_COL: goal_c <= cfg_data[COORD_BITS-1:0];
          REG_GOAL_ROW: goal_r <= cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        outcome_q.insert(outcome_q.size(), grow_tree(operation, sample_col, sample_row));
      if (done) begin
        if (outcome_q.size() == 0) begin
          $error("result with no request pending: status %0d", status);
          fail_count <= fail_count + 1;
        end else begin
          e = outcome_q.pop_front();
          if (e.st == ST_ADDED || e.st == ST_PLANT) begin
            last_col <= e.col;
            last_row <= e.row;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            fail_count <= fail_count + 1;
          end
          if (new_col !== e.col) begin
            $error("new_col expected %0d actual %0d", e.col, new_col);
            fail_count <= fail_count + 1;
          end
          if (new_row !== e.row) begin
            $error("new_row expected %0d actual %0d", e.row, new_row);
            fail_count <= fail_count + 1;
          end
          if (parent_index !== e.parent) begin
            $error("parent_index expected %0d actual %0d", e.parent, parent_index);
            fail_count <= fail_count + 1;
          end
          if (node_index !== e.idx) begin
            $error("node_index expected %0d actual %0d", e.idx, node_index);
            fail_count <= fail_count + 1;
          end
          if (reached_goal !== e.goal) begin
            $error("reached_goal expected %0d actual %0d", e.goal, reached_goal);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_rrt_tree_extend_unit.sv =====
// tb_rrt_tree_extend_unit: stimulus and verdict for the tree extend unit
// depends on rrt_pkg, rrt_tree_extend_unit and rrt_tree_extend_checker
`timescale 1ns / 100ps

module tb_rrt_tree_extend_unit;
  import rrt_pkg::*;

  logic clk, rst, start, busy, operation, cfg_valid, cfg_ready, done, reached_goal;
  logic [COORD_BITS-1:0] sample_col, sample_row, new_col, new_row, last_col, last_row;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic [2:0] status;
  logic [IDX_BITS-1:0] parent_index, node_index;
  int fail_count, pending, node_total, idle_pct, quiet_cycles;

  localparam int QUIET_LIMIT = 50000;

  rrt_tree_extend_unit u_dut (.*);
  rrt_tree_extend_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL rrt_tree_extend_unit");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait until every result is back, then the block's drain time
  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // hold start for the one cycle in which busy is low at the edge
  task automatic send_request(input logic op, input int c, input int r);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    operation <= op;
    sample_col <= COORD_BITS'(c);
    sample_row <= COORD_BITS'(r);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int pct);
    int c, r;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(19))
        0: send_request(1'b0, $urandom, $urandom);
        1, 2: send_request(1'b1, last_col, last_row);
        3, 4: begin
          c = int'(last_col) + $urandom_range(6) - 3;
          r = int'(last_row) + $urandom_range(6) - 3;
          send_request(1'b1, c, r);
        end
        default: send_request(1'b1, $urandom, $urandom);
      endcase
      // occasionally start over so the tree stays small
      if (node_total > 60 && $urandom_range(9) == 0) send_request(1'b0, 0, 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = 1'b0;
    sample_col = '0;
    sample_row = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: empty tree, plant, extremes, duplicate, goal
    send_request(1'b1, 5, 5);
    send_request(1'b0, 1023, 1023);
    send_request(1'b1, 0, 0);
    send_request(1'b1, 1023, 1023);
    send_request(1'b1, 1023, 0);
    send_request(1'b1, 0, 1023);
    send_request(1'b1, 99, 99);
    send_request(1'b1, 99, 99);
    send_request(1'b1, 100, 100);
    drain();
    write_reg(REG_STEP, 0);
    write_reg(REG_ROOT_COL, 1023);
    write_reg(REG_ROOT_ROW, 0);
    write_reg(REG_GOAL_COL, 1023);
    write_reg(REG_GOAL_ROW, 1);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 500, 500);
    send_request(1'b1, 1023, 0);
    drain();
    write_reg(REG_STEP, 1);
    send_request(1'b1, 1023, 700);
    drain();
    write_reg(REG_STEP, 1446);
    write_reg(REG_ROOT_COL, 0);
    write_reg(REG_ROOT_ROW, 1023);
    write_reg(REG_GOAL_COL, 1023);
    write_reg(REG_GOAL_ROW, 0);
    send_request(1'b0, 0, 0);
    send_request(1'b1, 1023, 0);
    send_request(1'b1, 512, 511);
    drain();

    // fill the tree to the limit with a long step, idling changes along the way
    write_reg(REG_STEP, 1446);
    write_reg(REG_ROOT_COL, 0);
    write_reg(REG_ROOT_ROW, 0);
    send_request(1'b0, 0, 0);
    for (int k = 1; k < MAX_NODES; k++) begin
      idle_pct = (k < 171) ? 14 : (k < 341) ? 72 : 0;
      send_request(1'b1, k % 32 * 30, k / 32 * 60);
    end
    idle_pct = 0;
    send_request(1'b1, 7, 7);
    send_request(1'b1, 1000, 1000);
    drain();

    // short random phases across register settings
    write_reg(REG_STEP, 50);
    write_reg(REG_ROOT_COL, $urandom_range(1023));
    write_reg(REG_ROOT_ROW, $urandom_range(1023));
    send_request(1'b0, 0, 0);
    random_phase(8, 14);
    drain();
    write_reg(REG_STEP, $urandom_range(1, 300));
    write_reg(REG_GOAL_COL, last_col);
    write_reg(REG_GOAL_ROW, last_row);
    random_phase(8, 72);
    drain();
    write_reg(REG_STEP, $urandom_range(1, 20));
    write_reg(REG_ROOT_COL, 512);
    write_reg(REG_ROOT_ROW, 512);
    send_request(1'b0, 0, 0);
    random_phase(8, 0);
    drain();

    if (fail_count == 0) $display("PASS rrt_tree_extend_unit");
    else $display("FAIL rrt_tree_extend_unit");
    $finish;
  end

endmodule

// ===== rrt_tree_extend_unit.f =====
rtl/rrt_pkg.sv
rtl/rrt_ram.sv
rtl/rrt_divsqrt.sv
rtl/rrt_tree_extend_unit.sv
test/rrt_tree_extend_checker.sv
test/tb_rrt_tree_extend_unit.sv
